>>> rtl/shb_pkg.sv
package shb_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_MULT_COUNT = 1'b1;

  localparam int SIZE_W  = 17;
  localparam int COUNT_W = 6;
  localparam int ECNT_W  = 7;

  localparam logic [SIZE_W-1:0]  TABLE_SIZE_RESET = 17'd1024;
  localparam logic [SIZE_W-1:0]  TABLE_SIZE_LIMIT = 17'd65536;
  localparam logic [COUNT_W-1:0] MULT_COUNT_RESET = 6'd20;

  // effective (clamped) configuration seen by front and back
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ECNT_W-1:0] count;
  } shb_cfg_t;

endpackage

>>> rtl/string_bucket_hash.sv
// String bucket hash.
// Input channel (in_valid/in_ready) takes one request per handshake:
//   a load request (in_req_type = 0) writes in_mult_value into multiplier
//   entry in_mult_index; a key request (in_req_type = 1) delivers in_key_byte.
// A nonzero byte is multiplied by the current multiplier and accumulated;
// a zero byte ends the key and yields one result on the output channel
// (out_valid/out_ready): out_bucket_index = sum mod table_size, and
// out_raw_sum = low 32 bits of the sum.
// A key byte takes a table read, then a multiply-add, with in_ready low during
// the multiply-add; a load or a terminator leaves the front idle. The remainder
// is computed by a bit-serial divider behind a 2-entry queue, so it overlaps
// the next key. A result passes through the queue, the divider's run and done
// states and the output register before out_valid rises.
// The user must write configuration (cfg_we/cfg_index/cfg_wdata) only while idle;
// the block does not enforce it. Index 0 is table_size, index 1 is mult_count.
// Reset clears the running sum, position, queue and output, and restores
// table_size = 1024 and mult_count = 20; multipliers must be loaded before use.
// When the receiver stalls, the result holds in the output register; the divider
// finishes its key and waits, the queue keeps filling, and in_ready drops once it is full.
module string_bucket_hash
  import shb_pkg::*;
#(
  parameter int MAX_MULTS = 32,
  parameter int SUM_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [7:0]        in_key_byte,
  input  logic [4:0]        in_mult_index,
  input  logic [31:0]       in_mult_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_bucket_index,
  output logic [31:0]       out_raw_sum,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  logic [SIZE_W-1:0]    table_size_r;
  logic [COUNT_W-1:0]   mult_count_r;
  shb_cfg_t             cfg;
  logic                 q_full, q_valid, q_pop, push_valid;
  logic [SUM_WIDTH-1:0] push_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RESET;
      mult_count_r <= MULT_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_SIZE: table_size_r <= cfg_wdata;
        CFG_MULT_COUNT: mult_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (table_size_r == '0)                   cfg.size = SIZE_W'(1);
    else if (table_size_r > TABLE_SIZE_LIMIT) cfg.size = TABLE_SIZE_LIMIT;
    else                                      cfg.size = table_size_r;
    if (mult_count_r == '0)                         cfg.count = ECNT_W'(1);
    else if ({1'b0, mult_count_r} > ECNT_W'(MAX_MULTS)) cfg.count = ECNT_W'(MAX_MULTS);
    else                                            cfg.count = {1'b0, mult_count_r};
  end

  shb_front #(
    .MAX_MULTS (MAX_MULTS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_key_byte   (in_key_byte),
    .in_mult_index (in_mult_index),
    .in_mult_value (in_mult_value),
    .cfg           (cfg),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_data     (push_data)
  );

  shb_queue #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  shb_divider #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_divider (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .cfg              (cfg),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bucket_index (out_bucket_index),
    .out_raw_sum      (out_raw_sum)
  );

endmodule

>>> rtl/shb_front.sv
module shb_front
  import shb_pkg::*;
#(
  parameter int MAX_MULTS = 32,
  parameter int SUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [7:0]           in_key_byte,
  input  logic [4:0]           in_mult_index,
  input  logic [31:0]          in_mult_value,
  input  shb_cfg_t             cfg,
  input  logic                 q_full,
  output logic                 push_valid,
  output logic [SUM_WIDTH-1:0] push_data
);

  localparam int PW = (MAX_MULTS > 1) ? $clog2(MAX_MULTS) : 1;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_MAC  = 1'b1;

  logic                 state_r, state_nxt;
  logic [SUM_WIDTH-1:0] sum_r, sum_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [7:0]           byte_r;
  logic [31:0]          mult_q;
  logic [31:0]          mem [MAX_MULTS];
  logic [PW-1:0]        wr_addr;
  logic [39:0]          prod;
  logic [ECNT_W-1:0]    pos_inc;
  logic                 accept;

  assign in_ready = (state_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign wr_addr  = PW'(in_mult_index);

  assign push_valid = accept && (in_req_type == REQ_KEY) && (in_key_byte == 8'd0);
  assign push_data  = sum_r;

  assign prod    = byte_r * mult_q;
  assign pos_inc = ECNT_W'(pos_r) + ECNT_W'(1);

  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_LOAD) && (in_mult_index < MAX_MULTS)) begin
      mem[wr_addr] <= in_mult_value;
    end
    if (accept && (in_req_type == REQ_KEY)) begin
      mult_q <= mem[pos_r];
      byte_r <= in_key_byte;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && (in_req_type == REQ_KEY)) begin
          if (in_key_byte == 8'd0) begin
            sum_nxt = '0;
            pos_nxt = '0;
          end else begin
            state_nxt = F_MAC;
          end
        end
      end
      F_MAC: begin
        sum_nxt   = sum_r + SUM_WIDTH'(prod);
        // a position left beyond a lowered count still wraps here
        pos_nxt   = (pos_inc >= cfg.count) ? '0 : PW'(pos_inc);
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      sum_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

>>> rtl/shb_queue.sv
module shb_queue #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  logic [SUM_WIDTH-1:0] push_data,
  output logic                 q_full,
  output logic                 q_valid,
  output logic [SUM_WIDTH-1:0] q_data,
  input  logic                 q_pop
);

  logic [SUM_WIDTH-1:0] data_r [2];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [1:0]           count_r;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'd2);
  assign q_data  = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_valid) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_valid) wr_ptr_r <= !wr_ptr_r;
      if (q_pop)      rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push_valid) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/shb_divider.sv
module shb_divider
  import shb_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [SUM_WIDTH-1:0] q_data,
  output logic                 q_pop,
  input  shb_cfg_t             cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_bucket_index,
  output logic [31:0]          out_raw_sum
);

  localparam int CW = $clog2(SUM_WIDTH + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r;
  logic [SUM_WIDTH-1:0] dividend_r;
  logic [SIZE_W-1:0]    rem_r, div_r;
  logic [31:0]          raw_r, raw_in;
  logic [SIZE_W:0]      trial;
  logic                 out_valid_r;
  logic                 load_out;

  generate
    if (SUM_WIDTH >= 32) begin : g_raw_trunc
      assign raw_in = q_data[31:0];
    end else begin : g_raw_ext
      assign raw_in = {{(32 - SUM_WIDTH){1'b0}}, q_data};
    end
  endgenerate

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_r, dividend_r[SUM_WIDTH-1]};

  assign q_pop    = (state_r == B_IDLE) && q_valid;
  assign load_out = (state_r == B_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (q_valid) state_nxt = B_RUN;
      B_RUN:   if (cnt_r == CW'(1)) state_nxt = B_DONE;
      B_DONE:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dividend_r <= q_data;
      raw_r      <= raw_in;
      rem_r      <= '0;
      div_r      <= cfg.size;
      cnt_r      <= CW'(SUM_WIDTH);
    end else if (state_r == B_RUN) begin
      dividend_r <= dividend_r << 1;
      rem_r      <= (trial >= {1'b0, div_r}) ? SIZE_W'(trial - {1'b0, div_r})
                                            : trial[SIZE_W-1:0];
      cnt_r      <= cnt_r - CW'(1);
    end
    if (load_out) begin
      out_bucket_index <= rem_r[15:0];
      out_raw_sum      <= raw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

>>> rtl/shb_checker.sv
module shb_checker
  import shb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_req_type,
  input logic [7:0]        in_key_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [15:0]       out_bucket_index,
  input logic [31:0]       out_raw_sum
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bucket_index) && $stable(out_raw_sum))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a nonzero byte occupies the multiply-add cycle
  a_mac_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_KEY) && (in_key_byte != 8'd0)
    |=> !in_ready)
    else $error("request taken during multiply-add");

  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_ready) && !$isunknown(out_valid))
    else $error("handshake output unknown");

endmodule

bind string_bucket_hash shb_checker u_shb_checker (.*);
